// ===== rtl/depth_to_normal_map_macros.svh =====
// Assertion macros used by the d2n_checker module.
`ifndef DEPTH_TO_NORMAL_MAP_MACROS_SVH
`define DEPTH_TO_NORMAL_MAP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define D2N_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("d2n assertion failed");

// Next-cycle implication, disabled in reset.
`define D2N_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("d2n assertion failed");

`endif

// ===== rtl/d2n_pkg.sv =====
// ----------------------------------------------------------------------------
// d2n_pkg
// Types and constants of the depth to normal map block.
// ----------------------------------------------------------------------------
package d2n_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int DEPTH_BITS = 24;
  localparam int FRAC_BITS  = 8;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CELL_W     = DEPTH_BITS + 1;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [23:0] depth_value;
    logic               depth_absent;
    logic               frame_first;
  } in_beat_t;

  typedef struct packed {
    logic [10:0] pixel_column;
    logic [11:0] pixel_row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic wr;
    logic slope;
    logic sq_x;
    logic sq_y;
    logic qsum;
    logic tgt;
    logic mul;
    logic cmp;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic ctr_absent;
    logic root_last;
    logic comp_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/depth_to_normal_map.sv =====
// ----------------------------------------------------------------------------
// depth_to_normal_map
// Raster depth stream in, RGB normal per interior pixel out.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i): one depth sample per beat
// in raster order; frame_first restarts the position at pixel (0,0).
// Output channel (out_valid_o/out_ready_i/out_data_o): one beat per interior
// pixel with its column, row and color; border pixels give nothing.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 image width, index 1
// image height; always ready, write only while the block is idle.
// Throughput: one sample at a time. A border sample takes a line buffer
// read, then a write and window shift. An interior sample with an absent
// center skips the root search; otherwise the time is set by the shared
// root search: 7 multiply/compare steps for each of the three components.
// The result sits in an output register, so the next sample is taken
// while it waits; a stalled receiver blocks only the next load.
// Reset clears position, window, output valid and restores 640x480. The
// line buffers are not cleared.
// ----------------------------------------------------------------------------
module depth_to_normal_map (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  d2n_pkg::in_beat_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output d2n_pkg::out_beat_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [d2n_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [d2n_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  d2n_pkg::cmd_t                 cmd;
  d2n_pkg::sts_t                 sts;
  logic [d2n_pkg::COL_W-1:0]     ram_addr;
  logic                          ram_we;
  logic [2*d2n_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  d2n_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  d2n_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .ram_addr_o  (ram_addr),
    .ram_we_o    (ram_we),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  d2n_ram #(
    .WIDTH (2 * d2n_pkg::CELL_W),
    .DEPTH (d2n_pkg::MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== rtl/d2n_ram.sv =====
// ----------------------------------------------------------------------------
// d2n_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module d2n_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/d2n_ctrl.sv =====
// ----------------------------------------------------------------------------
// d2n_ctrl
// Sequencer: line buffer access, slope, length and per-component root search.
// ----------------------------------------------------------------------------
module d2n_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  d2n_pkg::sts_t sts_i,
  output d2n_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_SLOPE = 4'd3;
  localparam logic [3:0] S_SQX   = 4'd4;
  localparam logic [3:0] S_SQY   = 4'd5;
  localparam logic [3:0] S_QSUM  = 4'd6;
  localparam logic [3:0] S_TGT   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_CMP   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: state_d = S_WRITE;
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = sts_i.emit ? S_SLOPE : S_IDLE;
      end
      S_SLOPE: begin
        cmd_o.slope = 1'b1;
        state_d     = S_SQX;
      end
      S_SQX: begin
        state_d    = sts_i.ctr_absent ? S_FIN : S_SQY;
        cmd_o.sq_x = 1'b1;
      end
      S_SQY: begin
        cmd_o.sq_y = 1'b1;
        state_d    = S_QSUM;
      end
      S_QSUM: begin
        cmd_o.qsum = 1'b1;
        state_d    = S_TGT;
      end
      S_TGT: begin
        cmd_o.tgt = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.root_last) begin
          state_d = sts_i.comp_last ? S_FIN : S_TGT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/d2n_datapath.sv =====
// ----------------------------------------------------------------------------
// d2n_datapath
// Position counters, 3x3 window, slopes, length and the scaled root unit.
// ----------------------------------------------------------------------------
module d2n_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  d2n_pkg::in_beat_t              in_data_i,
  input  logic                           cfg_valid_i,
  input  logic [d2n_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [d2n_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  d2n_pkg::cmd_t                  cmd_i,
  output d2n_pkg::sts_t                  sts_o,
  output logic [d2n_pkg::COL_W-1:0]      ram_addr_o,
  output logic                           ram_we_o,
  output logic [2*d2n_pkg::CELL_W-1:0]   ram_wdata_o,
  input  logic [2*d2n_pkg::CELL_W-1:0]   ram_rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output d2n_pkg::out_beat_t             out_data_o
);

  localparam int COLW  = d2n_pkg::COL_W;
  localparam int ROWW  = d2n_pkg::ROW_W;
  localparam int CW    = d2n_pkg::CELL_W;
  localparam int DB    = d2n_pkg::DEPTH_BITS;
  localparam int SW    = DB + 2;
  localparam int SQW   = 2 * SW;
  localparam int QW    = SQW + 1;
  localparam int TW    = SQW + 14;
  localparam int PW    = QW + 14;
  localparam logic [QW-1:0] S2    = QW'(1) << (2 * d2n_pkg::FRAC_BITS + 2);
  localparam logic [13:0]   RT_SQ = 14'd16129;

  logic [d2n_pkg::WIDTH_W-1:0]  width_q;
  logic [d2n_pkg::HEIGHT_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= d2n_pkg::WIDTH_W'(640);
      height_q <= d2n_pkg::HEIGHT_W'(480);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        d2n_pkg::REG_WIDTH:  width_q  <= cfg_data_i[d2n_pkg::WIDTH_W-1:0];
        d2n_pkg::REG_HEIGHT: height_q <= cfg_data_i[d2n_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COLW:0] w_lim, col0, ncol;
  logic [ROWW:0] h_lim, row0, nrow;

  always_comb begin
    if (width_q < d2n_pkg::WIDTH_W'(3)) begin
      w_lim = (COLW+1)'(3);
    end else if (int'(width_q) > d2n_pkg::MAX_WIDTH) begin
      w_lim = (COLW+1)'(d2n_pkg::MAX_WIDTH);
    end else begin
      w_lim = (COLW+1)'(width_q);
    end
    if (height_q < d2n_pkg::HEIGHT_W'(3)) begin
      h_lim = (ROWW+1)'(3);
    end else if (int'(height_q) > d2n_pkg::MAX_HEIGHT) begin
      h_lim = (ROWW+1)'(d2n_pkg::MAX_HEIGHT);
    end else begin
      h_lim = (ROWW+1)'(height_q);
    end
  end

  logic [COLW-1:0] col_q, c_q;
  logic [ROWW-1:0] row_q, r_q;
  logic [CW-1:0]   cell_q;
  logic            emit_q;

  always_comb begin
    col0 = in_data_i.frame_first ? '0 : {1'b0, col_q};
    row0 = in_data_i.frame_first ? '0 : {1'b0, row_q};
    if (col0 >= w_lim) begin
      col0 = '0;
      row0 = row0 + 1'b1;
    end
    if (row0 >= h_lim) begin
      row0 = '0;
    end
    ncol = col0 + 1'b1;
    nrow = row0;
    if (ncol >= w_lim) begin
      ncol = '0;
      nrow = row0 + 1'b1;
      if (nrow >= h_lim) begin
        nrow = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      emit_q <= 1'b0;
    end else if (cmd_i.accept) begin
      col_q  <= ncol[COLW-1:0];
      row_q  <= nrow[ROWW-1:0];
      emit_q <= (row0 >= (ROWW+1)'(2)) && (col0 >= (COLW+1)'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      c_q    <= col0[COLW-1:0];
      r_q    <= row0[ROWW-1:0];
      cell_q <= {in_data_i.depth_absent, in_data_i.depth_value};
    end
  end

  // line buffer word: {upper, middle}
  assign ram_addr_o  = c_q;
  assign ram_we_o    = cmd_i.wr;
  assign ram_wdata_o = {ram_rdata_i[CW-1:0], cell_q};

  logic [CW-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (cmd_i.wr) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= ram_rdata_i[2*CW-1:CW];
      win_q[1][2] <= ram_rdata_i[CW-1:0];
      win_q[2][2] <= cell_q;
    end
  end

  function automatic logic signed [SW-1:0] slope_f(input logic [CW-1:0] a,
                                                  input logic [CW-1:0] ctr,
                                                  input logic [CW-1:0] b);
    logic signed [SW-1:0] va, vc, vb;
    logic signed [SW-1:0] res;
    va = SW'($signed(a[DB-1:0]));
    vc = SW'($signed(ctr[DB-1:0]));
    vb = SW'($signed(b[DB-1:0]));
    case ({a[DB], b[DB]})
      2'b00:   res = vb - va;
      2'b10:   res = (vb - vc) <<< 1;
      2'b01:   res = (vc - va) <<< 1;
      default: res = '0;
    endcase
    return res;
  endfunction

  logic signed [SW-1:0] sx_q, sy_q;
  logic                 abs_q;
  logic [SW-1:0]        mag_x, mag_y, sq_a;
  logic [SQW-1:0]       sq_p, sqx_q, sqy_q, mag2;
  logic [QW-1:0]        q_q;
  logic [TW-1:0]        target_q;
  logic [PW-1:0]        prod_q;
  logic [1:0]           k_q;
  logic [6:0]           n_q, bit_q, cand, n_nx;
  logic [13:0]          cand_sq;
  logic [6:0]           res_q [3];

  assign mag_x   = sx_q[SW-1] ? SW'(-sx_q) : SW'(sx_q);
  assign mag_y   = sy_q[SW-1] ? SW'(-sy_q) : SW'(sy_q);
  assign sq_a    = cmd_i.sq_x ? mag_x : mag_y;
  assign sq_p    = SQW'(sq_a) * SQW'(sq_a);
  assign cand    = n_q | bit_q;
  assign cand_sq = 14'(cand) * 14'(cand);
  assign n_nx    = (prod_q <= PW'(target_q)) ? cand : n_q;

  always_comb begin
    case (k_q)
      2'd0:    mag2 = sqx_q;
      2'd1:    mag2 = sqy_q;
      default: mag2 = SQW'(S2);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      bit_q <= '0;
    end else begin
      if (cmd_i.slope) begin
        k_q <= '0;
      end
      if (cmd_i.tgt) begin
        bit_q <= 7'd64;
      end else if (cmd_i.cmp) begin
        bit_q <= bit_q >> 1;
        if (bit_q[0]) begin
          k_q <= k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.slope) begin
      sx_q  <= slope_f(win_q[1][0], win_q[1][1], win_q[1][2]);
      sy_q  <= slope_f(win_q[0][1], win_q[1][1], win_q[2][1]);
      abs_q <= win_q[1][1][DB];
    end
    if (cmd_i.sq_x) begin
      sqx_q <= sq_p;
    end
    if (cmd_i.sq_y) begin
      sqy_q <= sq_p;
    end
    if (cmd_i.qsum) begin
      q_q <= QW'(sqx_q) + QW'(sqy_q) + S2;
    end
    if (cmd_i.tgt) begin
      target_q <= TW'(mag2) * TW'(RT_SQ);
      n_q      <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(q_q) * PW'(cand_sq);
    end
    if (cmd_i.cmp) begin
      n_q <= n_nx;
      if (bit_q[0]) begin
        res_q[k_q] <= n_nx;
      end
    end
  end

  logic [7:0] red, green, blue;

  always_comb begin
    if (abs_q) begin
      red   = 8'h80;
      green = 8'h80;
      blue  = 8'hff;
    end else begin
      red   = sx_q[SW-1] ? 8'(8'd128 - {1'b0, res_q[0]}) : 8'(8'd128 + {1'b0, res_q[0]});
      green = sy_q[SW-1] ? 8'(8'd128 - {1'b0, res_q[1]}) : 8'(8'd128 + {1'b0, res_q[1]});
      blue  = 8'(8'd128 + {1'b0, res_q[2]});
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_o.pixel_column <= 11'(c_q - 1'b1);
      out_data_o.pixel_row    <= 12'(r_q - 1'b1);
      out_data_o.red          <= red;
      out_data_o.green        <= green;
      out_data_o.blue         <= blue;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sts_o.emit       = emit_q;
  assign sts_o.ctr_absent = win_q[1][1][DB];
  assign sts_o.root_last  = bit_q[0];
  assign sts_o.comp_last  = (k_q == 2'd2);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/d2n_checker.sv =====
// ----------------------------------------------------------------------------
// d2n_checker
// Port-level checks of the depth to normal map block.
// ----------------------------------------------------------------------------
`include "depth_to_normal_map_macros.svh"

module d2n_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input d2n_pkg::out_beat_t out_data_o
);

  `D2N_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `D2N_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `D2N_ASSERT_IMPL(a_interior, clk_i, rst_ni, out_valid_o, (out_data_o.pixel_column != 11'd0) && (out_data_o.pixel_row != 12'd0))
  `D2N_ASSERT_IMPL(a_blue_half, clk_i, rst_ni, out_valid_o, out_data_o.blue[7])

endmodule

bind depth_to_normal_map d2n_checker u_chk (.*);

// ===== tb/sv/depth_to_normal_map_checker.sv =====
// ----------------------------------------------------------------------------
// depth_to_normal_map_checker
// Watches the config, sample and normal channels of the depth to normal map
// block. It tracks the image geometry, line buffers and 3x3 window, and
// predicts each normal beat. Each normal beat is compared field by field
// with the oldest prediction. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module depth_to_normal_map_checker
  import d2n_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_beat_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_beat_t             out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [CELL_W-1:0] cell_t;

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  cell_t               upper_line [MAX_WIDTH];
  cell_t               middle_line [MAX_WIDTH];
  cell_t               win [3][3];
  int                  col_pos;
  int                  row_pos;
  out_beat_t           normal_q[$];
  int                  fails;

  assign fail_count_o = fails;
  assign pending_o    = normal_q.size();

  function automatic logic signed [63:0] depth_of(cell_t cl);
    logic signed [23:0] d;
    d = cl[DEPTH_BITS-1:0];
    return 64'(d);
  endfunction

  // slope from neighbor before (a), center and neighbor after (b)
  function automatic logic signed [63:0] slope_of(cell_t a, cell_t ctr, cell_t b);
    logic aa;
    logic ba;
    aa = a[DEPTH_BITS];
    ba = b[DEPTH_BITS];
    if (!aa && !ba) return depth_of(b) - depth_of(a);
    if (aa && ba) return 0;
    if (aa) return 2 * (depth_of(b) - depth_of(ctr));
    return 2 * (depth_of(ctr) - depth_of(a));
  endfunction

  // largest n in 0..127 with n^2 * q <= 127^2 * mag^2
  function automatic logic [7:0] scaled_root(logic [127:0] mag, logic [127:0] q);
    logic [127:0] tgt;
    logic [127:0] n;
    logic [127:0] c;
    tgt = mag * mag * 128'd16129;
    n = 0;
    for (int b = 64; b > 0; b >>= 1) begin
      c = n | 128'(b);
      if (q * (c * c) <= tgt) n = c;
    end
    return n[7:0];
  endfunction

  function automatic logic [7:0] color_of(logic signed [63:0] s, logic [127:0] q);
    logic [127:0] mag;
    logic [7:0]   n;
    mag = 128'(s < 0 ? -s : s);
    n = scaled_root(mag, q);
    return s < 0 ? 8'(128 - n) : 8'(128 + n);
  endfunction

  task automatic take_sample(in_beat_t b);
    int                  w;
    int                  h;
    int                  c;
    int                  r;
    cell_t               cl;
    cell_t               ctr;
    logic signed [63:0]  sx;
    logic signed [63:0]  sy;
    logic [127:0]        ax;
    logic [127:0]        ay;
    logic [127:0]        q;
    out_beat_t           e;
    w = width_reg < 3 ? 3 : (width_reg > MAX_WIDTH ? MAX_WIDTH : int'(width_reg));
    h = height_reg < 3 ? 3 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : int'(height_reg));
    cl = {b.depth_absent, b.depth_value};
    if (b.frame_first) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = middle_line[c];
    win[2][2] = cl;
    upper_line[c] = middle_line[c];
    middle_line[c] = cl;
    if (r >= 2 && c >= 2) begin
      ctr = win[1][1];
      e.pixel_column = 11'(c - 1);
      e.pixel_row    = 12'(r - 1);
      e.red          = 8'h80;
      e.green        = 8'h80;
      e.blue         = 8'hff;
      if (!ctr[DEPTH_BITS]) begin
        sx = slope_of(win[1][0], ctr, win[1][2]);
        sy = slope_of(win[0][1], ctr, win[2][1]);
        ax = 128'(sx < 0 ? -sx : sx);
        ay = 128'(sy < 0 ? -sy : sy);
        q = 128'd262144 + ax * ax + ay * ay;
        e.red   = color_of(sx, q);
        e.green = color_of(sy, q);
        e.blue  = 8'(128 + scaled_root(128'd512, q));
      end
      normal_q.push_back(e);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_normal(out_beat_t got);
    out_beat_t e;
    if (normal_q.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected normal beat %p", got);
    end else begin
      e = normal_q.pop_front();
      if (got.pixel_column !== e.pixel_column || got.pixel_row !== e.pixel_row ||
          got.red !== e.red || got.green !== e.green || got.blue !== e.blue) begin
        fails++;
        if (fails <= 10) $display("normal mismatch: expected %p, actual %p", e, got);
      end
    end
  endtask

  initial fails = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  <= 12'd640;
      height_reg <= 13'd480;
      col_pos    <= 0;
      row_pos    <= 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      normal_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_WIDTH) width_reg <= cfg_data_i[WIDTH_W-1:0];
        else if (cfg_index_i == REG_HEIGHT) height_reg <= cfg_data_i[HEIGHT_W-1:0];
      end
      if (out_valid_i && out_ready_i) check_normal(out_data_i);
      if (in_valid_i && in_ready_i) take_sample(in_data_i);
    end
  end

endmodule

// ===== tb/sv/tb_depth_to_normal_map.sv =====
// ----------------------------------------------------------------------------
// tb_depth_to_normal_map
// Drives depth frames of many geometries into the normal map block.
// A directed frame covers depth extremes and absent neighbors. Register
// writes cover the clamp limits and mid-frame geometry changes. Random
// frames follow, with bursts of idle cycles on both channels. The checker
// module does the prediction and comparison. This module gives the verdict.
// ----------------------------------------------------------------------------
module tb_depth_to_normal_map;
  import d2n_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;
  logic                  calm = 1'b0;
  int                    sent = 0;
  int                    stall_left = 0;

  depth_to_normal_map i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  depth_to_normal_map_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic put_sample(logic signed [23:0] v, logic a, logic f);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{depth_value: v, depth_absent: a, frame_first: f};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  // lets all normals drain and the last sample finish before a register write
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mode 0 smooth surface, 1 full random, 2 mostly absent
  task automatic send_pixels(int w, int n, int mode);
    logic signed [23:0] base;
    logic signed [23:0] v;
    int                 gx;
    int                 gy;
    logic               a;
    base = 24'($urandom);
    gx = $urandom_range(0, 2047) - 1024;
    gy = $urandom_range(0, 2047) - 1024;
    for (int k = 0; k < n; k++) begin
      if (mode == 1) v = 24'($urandom);
      else v = base + 24'(gx * (k % w) + gy * (k / w) + $urandom_range(0, 63) - 32);
      case (mode)
        0:       a = $urandom_range(0, 11) == 0;
        1:       a = $urandom_range(0, 5) == 0;
        default: a = $urandom_range(0, 2) != 0;
      endcase
      put_sample(v, a, k == 0 || (mode == 1 && $urandom_range(0, 199) == 0));
    end
  endtask

  task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    settle();
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
  endtask

  initial begin
    int w;
    int h;
    logic signed [23:0] v;
    logic a;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed 5x5 frame: extremes, absent center and each absent neighbor
    set_frame(16'd5, 16'd5);
    for (int k = 0; k < 25; k++) begin
      case (k % 4)
        0:       v = 24'sh7fffff;
        1:       v = 24'sh800000;
        2:       v = 24'sh000000;
        default: v = 24'sh000100;
      endcase
      a = (k == 6 || k == 12 || k == 16 || k == 17 || k == 19 || k == 23);
      put_sample(v, a, k == 0);
    end

    // clamp limits
    set_frame(16'hffff, 16'hffff);
    for (int k = 0; k < 64; k++) put_sample(24'($urandom), $urandom_range(0, 7) == 0, k == 0);
    // tall frame cut short by a height shrink, then a width shrink
    set_frame(16'd0, 16'd0);
    send_pixels(3, 21, 1);
    set_frame(16'd3, 16'd8191);
    send_pixels(3, 90, 0);
    settle();
    set_reg(REG_HEIGHT, 16'd4);
    send_pixels(3, 15, 1);
    set_frame(16'd10, 16'd6);
    send_pixels(10, 37, 0);
    settle();
    set_reg(REG_WIDTH, 16'd4);
    for (int k = 0; k < 30; k++) put_sample(24'($urandom), $urandom_range(0, 4) == 0, 1'b0);

    while (sent < 1650) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(20, 64);
        h = 3;
      end else begin
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 8);
      end
      set_frame(16'(w) | 16'($urandom_range(0, 15) << 12), 16'(h) | 16'($urandom_range(0, 7) << 13));
      if (sent > 1350) calm = 1'b1;
      repeat ($urandom_range(1, 3)) send_pixels(w, w * h, $urandom_range(0, 3) == 3 ? 2
                                                         : $urandom_range(0, 1));
    end

    settle();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/d2n_pkg.sv
rtl/d2n_ram.sv
rtl/d2n_ctrl.sv
rtl/d2n_datapath.sv
rtl/depth_to_normal_map.sv
rtl/d2n_checker.sv
tb/sv/depth_to_normal_map_checker.sv
tb/sv/tb_depth_to_normal_map.sv
